FILE: src/voxel_grid_face_culler_macros.svh
// Assertion helpers for the RTL, used by vgfc_ctrl. Each expects clk and rst in scope.
`ifndef VOXEL_GRID_FACE_CULLER_MACROS_SVH
`define VOXEL_GRID_FACE_CULLER_MACROS_SVH

// Same-cycle implication.
`define VGFC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VGFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vgfc_pkg.sv
package vgfc_pkg;

  // Grid geometry
  localparam int GRID_SIZE  = 32;
  localparam int TYPE_BITS  = 4;
  localparam int COORD_W    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int CRD_W     = 8;
  localparam int NT_W      = 4;
  localparam int BT_W      = 4;
  localparam int FACE_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Distance math: |d| up to 65535, limit up to 66047, sum of three squares
  localparam int ABS_W  = 17;
  localparam int DIFF_W = 18;
  localparam int SQ_W   = 34;
  localparam logic [ABS_W-1:0] MARGIN_Q88 = ABS_W'(512);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RENDER_DIST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSP_MASK = 3'd4;

  localparam logic [CFG_W-1:0] RENDER_DIST_RST = 16'd8192;
  localparam logic [CFG_W-1:0] TRANSP_MASK_RST = 16'd1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_MESH  = 2'd2
  } op_t;

  // Read select: center cell, then neighbors in face-bit order
  localparam int SEL_W = 3;
  localparam logic [SEL_W-1:0] SEL_CENTER = 3'd0;
  localparam logic [SEL_W-1:0] SEL_YP     = 3'd1;
  localparam logic [SEL_W-1:0] SEL_YN     = 3'd2;
  localparam logic [SEL_W-1:0] SEL_XN     = 3'd3;
  localparam logic [SEL_W-1:0] SEL_XP     = 3'd4;
  localparam logic [SEL_W-1:0] SEL_ZN     = 3'd5;
  localparam logic [SEL_W-1:0] SEL_ZP     = 3'd6;

  localparam logic [SEL_W-1:0] NB_LAST = SEL_W'(FACE_W - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_NEIGH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    SQ_NONE,
    SQ_LIM,
    SQ_DX,
    SQ_DY,
    SQ_DZ
  } sq_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LIM,
    ACC_FIRST,
    ACC_ADD
  } acc_t;

  typedef struct packed {
    logic             capture;
    logic             clr_en;
    logic             wr_en;
    logic             rd_en;
    logic [SEL_W-1:0] rd_sel;
    sq_t              sq_sel;
    acc_t             acc_op;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
  } status_t;

  // Types of 16 and up are opaque.
  function automatic logic is_transparent(logic [TYPE_BITS-1:0] t,
                                          logic [CFG_W-1:0] mask);
    logic [7:0] w;
    w = 8'(t);
    return (w < 8'd16) && mask[w[3:0]];
  endfunction

endpackage

FILE: src/vgfc_if.sv
interface vgfc_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [7:0] cell_x;
  logic signed [7:0] cell_y;
  logic signed [7:0] cell_z;
  logic [3:0]        new_type;

  modport source (output valid, opcode, cell_x, cell_y, cell_z, new_type, input ready);
  modport sink   (input valid, opcode, cell_x, cell_y, cell_z, new_type, output ready);
endinterface

interface vgfc_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] block_type;
  logic [5:0] face_mask;
  logic       distance_culled;

  modport source (output valid, block_type, face_mask, distance_culled, input ready);
  modport sink   (input valid, block_type, face_mask, distance_culled, output ready);
endinterface

interface vgfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vgfc_pkg::CFG_IDX_W-1:0]  index;
  logic [vgfc_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/vgfc_ctrl.sv
`include "voxel_grid_face_culler_macros.svh"

module vgfc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  vgfc_pkg::status_t status,
  output vgfc_pkg::cmd_t    cmd
);

  vgfc_pkg::state_t             state, state_next;
  logic [vgfc_pkg::SEL_W-1:0]   nb_cnt, nb_cnt_next;
  logic                         rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vgfc_pkg::ST_CLEAR;
      nb_cnt    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      nb_cnt    <= nb_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    nb_cnt_next = nb_cnt;
    unique case (state)
      vgfc_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = vgfc_pkg::ST_IDLE;
      end
      vgfc_pkg::ST_IDLE: begin
        if (req_valid) state_next = vgfc_pkg::ST_LOOKUP;
      end
      vgfc_pkg::ST_LOOKUP: begin
        nb_cnt_next = '0;
        unique case (status.op)
          vgfc_pkg::OP_READ: state_next = vgfc_pkg::ST_DRAIN;
          vgfc_pkg::OP_MESH: state_next = vgfc_pkg::ST_NEIGH;
          default:           state_next = vgfc_pkg::ST_DONE;
        endcase
      end
      vgfc_pkg::ST_NEIGH: begin
        if (nb_cnt == vgfc_pkg::NB_LAST) begin
          state_next = vgfc_pkg::ST_DRAIN;
        end else begin
          nb_cnt_next = nb_cnt + 3'd1;
        end
      end
      vgfc_pkg::ST_DRAIN: begin
        state_next = vgfc_pkg::ST_DONE;
      end
      vgfc_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = vgfc_pkg::ST_IDLE;
      end
      default: state_next = vgfc_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = vgfc_pkg::SEL_CENTER;
    cmd.sq_sel = vgfc_pkg::SQ_NONE;
    cmd.acc_op = vgfc_pkg::ACC_NONE;
    req_ready  = 1'b0;
    unique case (state)
      vgfc_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
      vgfc_pkg::ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      vgfc_pkg::ST_LOOKUP: begin
        cmd.sq_sel = vgfc_pkg::SQ_LIM;
        cmd.wr_en  = (status.op == vgfc_pkg::OP_WRITE);
        cmd.rd_en  = (status.op == vgfc_pkg::OP_READ) || (status.op == vgfc_pkg::OP_MESH);
      end
      vgfc_pkg::ST_NEIGH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = nb_cnt + vgfc_pkg::SEL_YP;
        // squarer runs alongside the neighbor reads
        unique case (nb_cnt)
          3'd0: begin
            cmd.sq_sel = vgfc_pkg::SQ_DX;
            cmd.acc_op = vgfc_pkg::ACC_LIM;
          end
          3'd1: begin
            cmd.sq_sel = vgfc_pkg::SQ_DY;
            cmd.acc_op = vgfc_pkg::ACC_FIRST;
          end
          3'd2: begin
            cmd.sq_sel = vgfc_pkg::SQ_DZ;
            cmd.acc_op = vgfc_pkg::ACC_ADD;
          end
          3'd3: cmd.acc_op = vgfc_pkg::ACC_ADD;
          default: ;
        endcase
      end
      vgfc_pkg::ST_DRAIN: ;
      vgfc_pkg::ST_DONE: cmd.load_out = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  assign rsp_valid_next = cmd.load_out || (rsp_valid && !rsp_ready);

  `VGFC_ASSERT_IMPLIES(a_load_free, cmd.load_out, !rsp_valid || rsp_ready, "result overwritten")
  `VGFC_ASSERT_NEXT(a_capture_lookup, cmd.capture, state == vgfc_pkg::ST_LOOKUP, "bad dispatch")
  `VGFC_ASSERT_IMPLIES(a_clear_busy, state == vgfc_pkg::ST_CLEAR, !req_ready, "accept in clear")
  `VGFC_ASSERT_IMPLIES(a_nb_range, state == vgfc_pkg::ST_NEIGH, nb_cnt <= vgfc_pkg::NB_LAST,
                       "neighbor count out of range")

endmodule

FILE: src/vgfc_datapath.sv
module vgfc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  vgfc_pkg::cmd_t                  cmd,
  output vgfc_pkg::status_t               status,
  input  logic [vgfc_pkg::OP_W-1:0]       opcode,
  input  logic signed [vgfc_pkg::CRD_W-1:0] cell_x,
  input  logic signed [vgfc_pkg::CRD_W-1:0] cell_y,
  input  logic signed [vgfc_pkg::CRD_W-1:0] cell_z,
  input  logic [vgfc_pkg::NT_W-1:0]       new_type,
  input  logic                            cfg_write,
  input  logic [vgfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vgfc_pkg::CFG_W-1:0]      cfg_data,
  output logic [vgfc_pkg::BT_W-1:0]       block_type,
  output logic [vgfc_pkg::FACE_W-1:0]     face_mask,
  output logic                            distance_culled
);

  localparam int AW = vgfc_pkg::ADDR_W;
  localparam int TW = vgfc_pkg::TYPE_BITS;
  localparam int CW = vgfc_pkg::COORD_W;
  localparam logic [AW-1:0] GRID_A = AW'(vgfc_pkg::GRID_SIZE);
  localparam logic [AW-1:0] CLR_LAST = AW'(vgfc_pkg::CELL_COUNT - 1);

  // config registers
  logic [vgfc_pkg::CFG_W-1:0] cam_x, cam_y, cam_z, render_dist, transp_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x       <= '0;
      cam_y       <= '0;
      cam_z       <= '0;
      render_dist <= vgfc_pkg::RENDER_DIST_RST;
      transp_mask <= vgfc_pkg::TRANSP_MASK_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vgfc_pkg::CFG_CAMERA_X:    cam_x       <= cfg_data;
        vgfc_pkg::CFG_CAMERA_Y:    cam_y       <= cfg_data;
        vgfc_pkg::CFG_CAMERA_Z:    cam_z       <= cfg_data;
        vgfc_pkg::CFG_RENDER_DIST: render_dist <= cfg_data;
        vgfc_pkg::CFG_TRANSP_MASK: transp_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured word
  logic [vgfc_pkg::OP_W-1:0]  op_q;
  logic [vgfc_pkg::CRD_W-1:0] x_q, y_q, z_q;
  logic [TW-1:0]              nt_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= opcode;
      x_q  <= cell_x;
      y_q  <= cell_y;
      z_q  <= cell_z;
      nt_q <= TW'(new_type);
    end
  end

  // neighbor address
  logic [8:0] off_x, off_y, off_z, ax, ay, az;
  logic       in_grid;
  logic [AW-1:0] addr, port_addr, clr_addr;

  always_comb begin
    off_x = '0;
    off_y = '0;
    off_z = '0;
    unique case (cmd.rd_sel)
      vgfc_pkg::SEL_YP: off_y = 9'd1;
      vgfc_pkg::SEL_YN: off_y = 9'h1FF;
      vgfc_pkg::SEL_XN: off_x = 9'h1FF;
      vgfc_pkg::SEL_XP: off_x = 9'd1;
      vgfc_pkg::SEL_ZN: off_z = 9'h1FF;
      vgfc_pkg::SEL_ZP: off_z = 9'd1;
      default: ;
    endcase
  end

  assign ax = {x_q[7], x_q} + off_x;
  assign ay = {y_q[7], y_q} + off_y;
  assign az = {z_q[7], z_q} + off_z;

  assign in_grid = !ax[8] && (ax[7:0] < 8'(vgfc_pkg::GRID_SIZE)) &&
                   !ay[8] && (ay[7:0] < 8'(vgfc_pkg::GRID_SIZE)) &&
                   !az[8] && (az[7:0] < 8'(vgfc_pkg::GRID_SIZE));

  assign addr = (AW'(ax[CW-1:0]) * GRID_A + AW'(ay[CW-1:0])) * GRID_A + AW'(az[CW-1:0]);
  assign port_addr = cmd.clr_en ? clr_addr : addr;

  // clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign status.clr_last = (clr_addr == CLR_LAST);
  assign status.op       = op_q;

  // block store, single port
  logic [TW-1:0] mem [vgfc_pkg::CELL_COUNT];
  logic [TW-1:0] mem_q;

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[port_addr] <= '0;
    end else if (cmd.wr_en && in_grid) begin
      mem[port_addr] <= nt_q;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[port_addr];
    end
  end

  // read tag travels with the data
  logic                       rd_pend_q, rd_in_q;
  logic [vgfc_pkg::SEL_W-1:0] rd_tag_q, fbit;
  logic [TW-1:0]              rd_val, center_q;
  logic [vgfc_pkg::FACE_W-1:0] faces_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_tag_q <= cmd.rd_sel;
      rd_in_q  <= in_grid;
    end
  end

  assign rd_val = rd_in_q ? mem_q : '0;
  assign fbit   = rd_tag_q - vgfc_pkg::SEL_YP;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      faces_q  <= '0;
      center_q <= '0;
    end else if (rd_pend_q) begin
      if (rd_tag_q == vgfc_pkg::SEL_CENTER) begin
        center_q <= rd_val;
      end else begin
        faces_q[fbit] <= vgfc_pkg::is_transparent(rd_val, transp_mask);
      end
    end
  end

  // distance: one squarer, result registered, then accumulated
  logic [vgfc_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [vgfc_pkg::ABS_W-1:0]  abs_x, abs_y, abs_z, sq_in;
  logic [vgfc_pkg::SQ_W-1:0]   prod_q, acc_q, lim_sq_q;
  logic                        over;

  // 256*cell in Q8.8, sign extended to the difference width
  assign dx = {{2{x_q[7]}}, x_q, 8'h00} - {{2{cam_x[15]}}, cam_x};
  assign dy = {{2{y_q[7]}}, y_q, 8'h00} - {{2{cam_y[15]}}, cam_y};
  assign dz = {{2{z_q[7]}}, z_q, 8'h00} - {{2{cam_z[15]}}, cam_z};
  assign abs_x = dx[17] ? 17'(-dx) : dx[16:0];
  assign abs_y = dy[17] ? 17'(-dy) : dy[16:0];
  assign abs_z = dz[17] ? 17'(-dz) : dz[16:0];

  always_comb begin
    unique case (cmd.sq_sel)
      vgfc_pkg::SQ_LIM: sq_in = 17'(render_dist) + vgfc_pkg::MARGIN_Q88;
      vgfc_pkg::SQ_DX:  sq_in = abs_x;
      vgfc_pkg::SQ_DY:  sq_in = abs_y;
      vgfc_pkg::SQ_DZ:  sq_in = abs_z;
      default:          sq_in = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_q <= vgfc_pkg::SQ_W'(sq_in) * vgfc_pkg::SQ_W'(sq_in);
    unique case (cmd.acc_op)
      vgfc_pkg::ACC_LIM:   lim_sq_q <= prod_q;
      vgfc_pkg::ACC_FIRST: acc_q    <= prod_q;
      vgfc_pkg::ACC_ADD:   acc_q    <= acc_q + prod_q;
      default: ;
    endcase
  end

  assign over = acc_q > lim_sq_q;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      block_type      <= '0;
      face_mask       <= '0;
      distance_culled <= 1'b0;
      unique case (op_q)
        vgfc_pkg::OP_READ: block_type <= vgfc_pkg::BT_W'(center_q);
        vgfc_pkg::OP_MESH: begin
          if (center_q != '0) begin
            block_type      <= vgfc_pkg::BT_W'(center_q);
            distance_culled <= over;
            face_mask       <= over ? '0 : faces_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/voxel_grid_face_culler.sv
// Channel  Dir  Payload                                   Handshake
// req      in   opcode, cell_x, cell_y, cell_z, new_type   valid/ready
// rsp      out  block_type, face_mask, distance_culled     valid/ready
// cfg      in   index, data (register write)               valid/ready, ready tied high
//
// Write runs lookup, done; read runs lookup, drain, done; mesh runs lookup,
// the neighbor walk, drain, done. A new word is taken once the last result is
// loaded. The mesh walk is set by the single port of the block store: center plus
// six neighbor reads, one per cycle, with the distance squarer hidden under them.
// Reset: synchronous; afterwards a clearing sweep writes air to all
// GRID_SIZE^3 cells with req.ready low; cfg writes are taken.
// Stalls: the result sits in an output register, so a new word is accepted
// while rsp is stalled; a finished word waits in the done state until the
// output register frees up.
module voxel_grid_face_culler (
  input  logic            clk,
  input  logic            rst,
  vgfc_req_if.sink        req,
  vgfc_rsp_if.source      rsp,
  vgfc_cfg_if.sink        cfg
);

  vgfc_pkg::cmd_t    cmd;
  vgfc_pkg::status_t status;
  logic              cfg_write;

  // config is always writable; software is to write only while the block is idle, which the block does not enforce
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  // sequencer: clear sweep, dispatch by opcode, neighbor walk, result handoff
  vgfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // store, config registers, distance squarer and result register
  vgfc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .opcode          (req.opcode),
    .cell_x          (req.cell_x),
    .cell_y          (req.cell_y),
    .cell_z          (req.cell_z),
    .new_type        (req.new_type),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .block_type      (rsp.block_type),
    .face_mask       (rsp.face_mask),
    .distance_culled (rsp.distance_culled)
  );

endmodule

FILE: test/voxel_grid_face_culler_test.sv
module voxel_grid_face_culler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vgfc_pkg::*;

  // Opcode with no function: the block answers with an all-zero word.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Register indexes past the last register: writes are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  localparam int  CLK_HALF     = 4;
  localparam int  RESET_CYCLES = 8;
  // Covers the clearing sweep plus ~760 words.
  localparam int  CYCLE_LIMIT  = 250000;
  localparam int  SETTLE       = 20;
  localparam int  PHASE_WORDS  = 122;
  localparam int  WINDOW       = 4;
  localparam int  MARGIN       = 512;

  typedef struct packed {
    logic [BT_W-1:0]   block_type;
    logic [FACE_W-1:0] face_mask;
    logic              distance_culled;
  } face_word_t;

  // Shadow copy of the grid and the registers; predicts one result word per
  // accepted request word and checks the result words in order.
  class grid_shadow;
    bit [TYPE_BITS-1:0] cells [CELL_COUNT];
    bit [CFG_W-1:0]     cam_x, cam_y, cam_z, reach, see_through;
    face_word_t         pending_faces [$];
    int                 mismatches;

    function new();
      cam_x       = '0;
      cam_y       = '0;
      cam_z       = '0;
      reach       = RENDER_DIST_RST;
      see_through = TRANSP_MASK_RST;
      mismatches  = 0;
    endfunction

    function bit in_grid(int x, int y, int z);
      return x >= 0 && x < GRID_SIZE && y >= 0 && y < GRID_SIZE &&
             z >= 0 && z < GRID_SIZE;
    endfunction

    function bit [TYPE_BITS-1:0] cell_at(int x, int y, int z);
      if (!in_grid(x, y, z)) return '0;
      return cells[(x * GRID_SIZE + y) * GRID_SIZE + z];
    endfunction

    function bit clear_type(bit [TYPE_BITS-1:0] t);
      int unsigned tv;
      tv = t;
      if (tv >= CFG_W) return 1'b0;
      return see_through[tv];
    endfunction

    function longint axis_sq(int c, bit [CFG_W-1:0] cam);
      longint d;
      d = longint'(c) * 256 - longint'($signed(cam));
      return d * d;
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] v);
      case (idx)
        CFG_CAMERA_X:    cam_x = v;
        CFG_CAMERA_Y:    cam_y = v;
        CFG_CAMERA_Z:    cam_z = v;
        CFG_RENDER_DIST: reach = v;
        CFG_TRANSP_MASK: see_through = v;
        default: ;
      endcase
    endfunction

    function void apply_word(bit [OP_W-1:0] op, bit signed [CRD_W-1:0] sx,
                             bit signed [CRD_W-1:0] sy, bit signed [CRD_W-1:0] sz,
                             bit [NT_W-1:0] nt);
      face_word_t         w;
      int                 x, y, z;
      bit [TYPE_BITS-1:0] t;
      longint             sq_sum, lim;
      w = '0;
      x = sx;
      y = sy;
      z = sz;
      case (op)
        OP_WRITE: begin
          if (in_grid(x, y, z)) cells[(x * GRID_SIZE + y) * GRID_SIZE + z] = TYPE_BITS'(nt);
        end
        OP_READ: begin
          w.block_type = BT_W'(cell_at(x, y, z));
        end
        OP_MESH: begin
          t = cell_at(x, y, z);
          w.block_type = BT_W'(t);
          if (t != '0) begin
            sq_sum = axis_sq(x, cam_x) + axis_sq(y, cam_y) + axis_sq(z, cam_z);
            lim    = longint'(reach) + MARGIN;
            if (sq_sum > lim * lim) begin
              w.distance_culled = 1'b1;
            end else begin
              w.face_mask = {clear_type(cell_at(x, y, z + 1)),
                             clear_type(cell_at(x, y, z - 1)),
                             clear_type(cell_at(x + 1, y, z)),
                             clear_type(cell_at(x - 1, y, z)),
                             clear_type(cell_at(x, y - 1, z)),
                             clear_type(cell_at(x, y + 1, z))};
            end
          end
        end
        default: ;
      endcase
      pending_faces.push_back(w);
    endfunction

    function void check_word(face_word_t got);
      face_word_t want;
      if (pending_faces.size() == 0) begin
        $display("%0t: result word expected none got %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_faces.pop_front();
      if (got.block_type !== want.block_type) begin
        $display("%0t: block_type expected %0d got %0d", $time,
                 want.block_type, got.block_type);
        mismatches++;
      end
      if (got.face_mask !== want.face_mask) begin
        $display("%0t: face_mask expected %b got %b", $time,
                 want.face_mask, got.face_mask);
        mismatches++;
      end
      if (got.distance_culled !== want.distance_culled) begin
        $display("%0t: distance_culled expected %0d got %0d", $time,
                 want.distance_culled, got.distance_culled);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  vgfc_req_if req_bus ();
  vgfc_rsp_if rsp_bus ();
  vgfc_cfg_if cfg_bus ();

  voxel_grid_face_culler dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  grid_shadow shadow = new();

  // Idle odds in percent, changed per phase.
  int send_gap_pct;
  int stall_pct;
  int cycle_count;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Result side: check the word taken at this edge, then pick next ready.
  always @(posedge clk) begin
    if (rsp_bus.valid && rsp_bus.ready)
      shadow.check_word('{rsp_bus.block_type, rsp_bus.face_mask, rsp_bus.distance_culled});
    rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: also covers a word whose result never shows up.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("voxel_grid_face_culler regression: fail");
    $finish;
  end

  // One request word: optional gap, then hold valid until taken. Valid is
  // left high so back-to-back words need no extra edge.
  task automatic send_word(logic [OP_W-1:0] op, logic [CRD_W-1:0] x,
                           logic [CRD_W-1:0] y, logic [CRD_W-1:0] z,
                           logic [NT_W-1:0] nt);
    while ($urandom_range(99) < send_gap_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.opcode   <= op;
    req_bus.cell_x   <= x;
    req_bus.cell_y   <= y;
    req_bus.cell_z   <= z;
    req_bus.new_type <= nt;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    shadow.apply_word(op, x, y, z, nt);
  endtask

  // Drop valid and hold off until every predicted word has come back.
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending_faces.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    shadow.set_reg(idx, v);
  endtask

  // All five registers plus one unmapped index; only called with the block idle.
  task automatic configure(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
                           logic [CFG_W-1:0] cz, logic [CFG_W-1:0] reach,
                           logic [CFG_W-1:0] clear_mask);
    write_reg(CFG_CAMERA_X, cx);
    write_reg(CFG_CAMERA_Y, cy);
    write_reg(CFG_CAMERA_Z, cz);
    write_reg(CFG_RENDER_DIST, reach);
    write_reg(CFG_TRANSP_MASK, clear_mask);
    write_reg(CFG_IDX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)),
              CFG_W'($urandom));
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Camera coordinate near the busy window, within about three cells.
  function automatic logic [CFG_W-1:0] cam_near(int base);
    return CFG_W'((base + WINDOW / 2) * 256 + int'($urandom_range(1535)) - 768);
  endfunction

  // Mostly inside a small window so writes pile up where meshing looks;
  // some anywhere around the grid, a few across the full 8-bit range.
  function automatic logic [CRD_W-1:0] pick_axis(int base);
    int r;
    r = $urandom_range(99);
    if (r < 75) return CRD_W'(base + int'($urandom_range(WINDOW - 1)));
    if (r < 90) return CRD_W'(int'($urandom_range(GRID_SIZE + 3)) - 2);
    return CRD_W'($urandom);
  endfunction

  task automatic run_phase(int base);
    logic [OP_W-1:0] op;
    int              r;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      r = $urandom_range(99);
      if (r < 40)      op = OP_WRITE;
      else if (r < 55) op = OP_READ;
      else if (r < 95) op = OP_MESH;
      else             op = OP_UNUSED;
      // Sender holds off for a full drain once per phase, and now and then.
      if (i == PHASE_WORDS / 2 || $urandom_range(99) < 2) drain();
      send_word(op, pick_axis(base), pick_axis(base), pick_axis(base),
                NT_W'($urandom_range(15)));
    end
    drain();
  endtask

  initial begin
    int base;
    rst              <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.opcode   <= OP_WRITE;
    req_bus.cell_x   <= '0;
    req_bus.cell_y   <= '0;
    req_bus.cell_z   <= '0;
    req_bus.new_type <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= CFG_CAMERA_X;
    cfg_bus.data     <= '0;
    send_gap_pct = 0;
    stall_pct    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the reset register values (camera at origin,
    // reach 32.0, only air see-through). The first send waits out the
    // clearing sweep.
    send_word(OP_WRITE, 8'd0, 8'd0, 8'd0, 4'd15);
    send_word(OP_READ,  8'd0, 8'd0, 8'd0, 4'd0);
    send_word(OP_MESH,  8'd0, 8'd0, 8'd0, 4'd0);     // corner, all faces open
    send_word(OP_WRITE, 8'd0, 8'd1, 8'd0, 4'd2);
    send_word(OP_MESH,  8'd0, 8'd0, 8'd0, 4'd0);     // +y now covered
    send_word(OP_WRITE, 8'd31, 8'd31, 8'd31, 4'd1);
    send_word(OP_READ,  8'd31, 8'd31, 8'd31, 4'd0);
    send_word(OP_MESH,  8'd31, 8'd31, 8'd31, 4'd0);  // far corner: culled
    send_word(OP_WRITE, 8'hFF, 8'd0, 8'd0, 4'd5);    // x = -1, dropped
    send_word(OP_READ,  8'hFF, 8'd0, 8'd0, 4'd0);
    send_word(OP_WRITE, 8'd32, 8'd0, 8'd0, 4'd6);    // x = 32, dropped
    send_word(OP_WRITE, 8'h7F, 8'h80, 8'h7F, 4'd9);
    send_word(OP_READ,  8'h80, 8'h7F, 8'h80, 4'd0);
    send_word(OP_MESH,  8'h80, 8'h80, 8'h80, 4'd0);  // outside reads as air
    send_word(OP_MESH,  8'd5, 8'd5, 8'd5, 4'd0);     // air cell
    send_word(OP_WRITE, 8'd0, 8'd0, 8'd0, 4'd0);     // erase back to air
    send_word(OP_MESH,  8'd0, 8'd1, 8'd0, 4'd0);
    send_word(OP_UNUSED, 8'd10, 8'd10, 8'd10, 4'd15);
    send_word(OP_READ,  8'd10, 8'd10, 8'd10, 4'd0);  // unused opcode stored nothing
    send_word(OP_WRITE, 8'd1, 8'd1, 8'd0, 4'd15);
    send_word(OP_MESH,  8'd0, 8'd1, 8'd0, 4'd0);     // +x covered
    send_word(OP_WRITE, 8'd0, 8'd2, 8'd0, 4'd8);
    send_word(OP_MESH,  8'd0, 8'd1, 8'd0, 4'd0);     // +y and +x covered
    send_word(OP_MESH,  8'd1, 8'd1, 8'd0, 4'd0);
    send_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 4'd15);
    drain();

    // Centered camera, widest reach, every type see-through; no idling.
    base = $urandom_range(GRID_SIZE - WINDOW);
    configure(16'd4096, 16'd4096, 16'd4096, 16'hFFFF, 16'hFFFF);
    run_phase(base);

    // Low edge of the grid, zero reach, nothing see-through; sender gaps.
    base = -1;
    send_gap_pct = 47;
    configure(cam_near(base), cam_near(base), cam_near(base), 16'h0000, 16'h0000);
    run_phase(base);

    // High edge, camera anywhere; receiver stalls.
    base = GRID_SIZE - WINDOW + 1;
    send_gap_pct = 0;
    stall_pct    = 47;
    configure(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
              CFG_W'($urandom), CFG_W'($urandom));
    run_phase(base);

    // Short reach around the window, air always see-through; light idling both sides.
    base = $urandom_range(GRID_SIZE - WINDOW);
    send_gap_pct = 8;
    stall_pct    = 8;
    configure(cam_near(base), cam_near(base), cam_near(base),
              CFG_W'($urandom_range(2048)), CFG_W'($urandom) | 16'h0001);
    run_phase(base);

    // Camera at the signed extremes, air opaque; no idling.
    base = $urandom_range(GRID_SIZE - WINDOW);
    send_gap_pct = 0;
    stall_pct    = 0;
    configure(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, CFG_W'($urandom) & 16'hFFFE);
    run_phase(base);

    // Near camera, random reach and mask; sender gaps again.
    base = $urandom_range(GRID_SIZE - WINDOW);
    send_gap_pct = 47;
    configure(cam_near(base), cam_near(base), cam_near(base),
              CFG_W'($urandom_range(4096)), CFG_W'($urandom));
    run_phase(base);

    repeat (SETTLE) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending_faces.size() == 0)
      $display("voxel_grid_face_culler regression: pass");
    else
      $display("voxel_grid_face_culler regression: fail");
    $finish;
  end

endmodule
